// File: rtl/agtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agtm_pkg
// Shared types, constants and the microprogram of the scan-group averager.
// ----------------------------------------------------------------------------
package agtm_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int GC_W           = 4;
    localparam int GROUPS_DEFAULT = 10;
    localparam int SUM_W          = 18;
    localparam int CNT_W          = 15;
    localparam int DIV_W          = 25;
    localparam int QUO_W          = 24;
    localparam int MUL_W          = 33;
    localparam int PROD_W         = 2 * MUL_W;
    localparam int RECIP_SHIFT    = 35;
    localparam int STEP_W         = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_W          = 32;
    localparam int VAL_W          = 32;
    localparam int UVAL_W         = 31;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 128;

    localparam logic [SUM_W-1:0]    REF_NOMINAL  = SUM_W'(1489);
    localparam logic [MUL_W-1:0]    RECIP_10     = 33'h0_CCCC_CCCD;
    localparam logic [DIV_W-1:0]    FLOOR_ADJ    = DIV_W'(9);
    localparam logic signed [PROD_W-1:0] DEG_OFFSET = 66'sd1638400;
    localparam logic signed [PROD_W-1:0] SAT_MAX    = 66'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_MIN    = -66'sd2147483648;

    localparam logic [VAL_W-1:0]  RST_SCALE_A   = 32'd0;
    localparam logic [VAL_W-1:0]  RST_OFFSET_A  = 32'd45875;
    localparam logic [VAL_W-1:0]  RST_SCALE_B   = 32'd0;
    localparam logic [UVAL_W-1:0] RST_SENSOR_V25 = 31'd93716;
    localparam logic [UVAL_W-1:0] RST_INV_SLOPE  = 31'd15241216;
    localparam logic [VAL_W-1:0]  RST_FILT_A    = 32'd786432;
    localparam logic [VAL_W-1:0]  RST_FILT_B    = 32'd275251;
    localparam logic [VAL_W-1:0]  RST_FILT_S    = 32'd88913;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_V25 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SLOPE  = 3'd4;

    localparam logic [1:0] SEQ_NEXT   = 2'd0;
    localparam logic [1:0] SEQ_INPUT  = 2'd1;
    localparam logic [1:0] SEQ_OUTPUT = 2'd2;

    localparam logic [1:0] A_DIV     = 2'd0;
    localparam logic [1:0] A_SCALE_A = 2'd1;
    localparam logic [1:0] A_SCALE_B = 2'd2;
    localparam logic [1:0] A_DIFF    = 2'd3;

    localparam logic [1:0] B_RECIP = 2'd0;
    localparam logic [1:0] B_CNT_A = 2'd1;
    localparam logic [1:0] B_CNT_B = 2'd2;
    localparam logic [1:0] B_INV   = 2'd3;

    localparam logic [1:0] D_SUM_A = 2'd0;
    localparam logic [1:0] D_SUM_B = 2'd1;
    localparam logic [1:0] D_SUM_S = 2'd2;
    localparam logic [1:0] D_XSENS = 2'd3;

    localparam logic [2:0] W_NONE   = 3'd0;
    localparam logic [2:0] W_CNT_A  = 3'd1;
    localparam logic [2:0] W_CNT_B  = 3'd2;
    localparam logic [2:0] W_CNT_S  = 3'd3;
    localparam logic [2:0] W_FILT_A = 3'd4;
    localparam logic [2:0] W_FILT_B = 3'd5;
    localparam logic [2:0] W_FILT_S = 3'd6;
    localparam logic [2:0] W_OUT    = 3'd7;

    typedef struct packed {
        logic [1:0] seq;
        logic       mul_en;
        logic [1:0] a_sel;
        logic [1:0] b_sel;
        logic [1:0] div_src;
        logic       div_floor;
        logic [2:0] wr_sel;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } cond_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{seq: SEQ_NEXT, mul_en: 1'b0, a_sel: A_DIV, b_sel: B_RECIP,
              div_src: D_SUM_A, div_floor: 1'b0, wr_sel: W_NONE};
        unique case (step)
            4'd0:
            begin
                c.seq = SEQ_INPUT;
            end
            4'd1:
            begin
                c.mul_en  = 1'b1;
                c.div_src = D_SUM_A;
            end
            4'd2:
            begin
                c.mul_en  = 1'b1;
                c.div_src = D_SUM_B;
                c.wr_sel  = W_CNT_A;
            end
            4'd3:
            begin
                c.mul_en  = 1'b1;
                c.div_src = D_SUM_S;
                c.wr_sel  = W_CNT_B;
            end
            4'd4:
            begin
                c.wr_sel = W_CNT_S;
            end
            4'd5:
            begin
                c.mul_en = 1'b1;
                c.a_sel  = A_SCALE_A;
                c.b_sel  = B_CNT_A;
            end
            4'd6:
            begin
                c.mul_en = 1'b1;
                c.a_sel  = A_SCALE_B;
                c.b_sel  = B_CNT_B;
                c.wr_sel = W_FILT_A;
            end
            4'd7:
            begin
                c.mul_en    = 1'b1;
                c.div_src   = D_XSENS;
                c.div_floor = 1'b1;
                c.wr_sel    = W_FILT_B;
            end
            4'd8:
            begin
                c.wr_sel = W_FILT_S;
            end
            4'd9:
            begin
                c.mul_en = 1'b1;
                c.a_sel  = A_DIFF;
                c.b_sel  = B_INV;
            end
            4'd10:
            begin
                c.seq    = SEQ_OUTPUT;
                c.wr_sel = W_OUT;
            end
            default:
            begin
                c.seq = SEQ_OUTPUT;
            end
        endcase
        return c;
    endfunction

    function automatic logic [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[VAL_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[VAL_W-1:0];
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/agtm_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agtm_sequencer
// Step counter and microprogram store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module agtm_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  agtm_pkg::cond_t cond,
    output agtm_pkg::ctrl_t ctrl
);
    import agtm_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.seq)
            SEQ_INPUT:  step_next = cond.start ? step_reg + STEP_W'(1) : step_reg;
            SEQ_OUTPUT: step_next = cond.out_free ? '0 : step_reg;
            default:    step_next = step_reg + STEP_W'(1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: rtl/adc_group_average_temp_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_group_average_temp_monitor
// Averages ADC scan groups, filters the voltages and reports die temperature.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_axis   | in        | one scan group of four 12-bit samples
// m_axis   | out       | filtered volts A, B, sensor and degrees, Q16.16
// cfg      | in        | register writes, index 0 to 4
//
// A scan group that does not close a run is taken on step 0. The group that
// closes a run starts an eleven-step microprogram sharing one 33x33 multiplier,
// so input is held off while steps 1 to 10 run. The result sits in an output
// register; input is taken while it waits, and the program only stalls on its
// final step if an earlier result has still not been taken. Reset is
// asynchronous and restores the register defaults and the filter state.
// ----------------------------------------------------------------------------
module adc_group_average_temp_monitor #(
    parameter int GROUPS = agtm_pkg::GROUPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_chan_a, sample_chan_b, sample_sensor, sample_reference
    input  logic [agtm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // volts_chan_a, volts_chan_b, volts_sensor, degrees
    output logic [agtm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [agtm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [agtm_pkg::CFG_W-1:0]          cfg_wdata
);
    import agtm_pkg::*;

    ctrl_t ctrl;
    cond_t cond;

    logic [VAL_W-1:0]  scale_a_reg;
    logic [VAL_W-1:0]  offset_a_reg;
    logic [VAL_W-1:0]  scale_b_reg;
    logic [UVAL_W-1:0] sensor_v25_reg;
    logic [UVAL_W-1:0] inv_slope_reg;

    logic [SUM_W-1:0] sum_a_reg;
    logic [SUM_W-1:0] sum_b_reg;
    logic [SUM_W-1:0] sum_s_reg;
    logic [GC_W-1:0]  group_count_reg;
    logic [GC_W-1:0]  group_count_next;

    logic signed [CNT_W-1:0] cnt_a_reg;
    logic signed [CNT_W-1:0] cnt_b_reg;
    logic signed [CNT_W-1:0] cnt_s_reg;
    logic signed [VAL_W-1:0] filt_a_reg;
    logic signed [VAL_W-1:0] filt_b_reg;
    logic signed [VAL_W-1:0] filt_s_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     sign_reg;

    logic                  out_valid_reg;
    logic [VAL_W-1:0]      out_a_reg;
    logic [VAL_W-1:0]      out_b_reg;
    logic [VAL_W-1:0]      out_s_reg;
    logic [VAL_W-1:0]      out_deg_reg;

    logic                  in_accept;
    logic                  last_group;
    logic [SUM_W-1:0]      smp_a;
    logic [SUM_W-1:0]      smp_b;
    logic [SUM_W-1:0]      smp_s;
    logic [SUM_W-1:0]      smp_r;

    logic signed [DIV_W-1:0] div_val;
    logic signed [DIV_W-1:0] x_sens;
    logic                    div_neg;
    logic [DIV_W-1:0]        div_mag;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic [QUO_W-1:0]         quo_mag;
    logic signed [DIV_W-1:0]  quo;
    logic signed [PROD_W-1:0] filt_a_sum;
    logic signed [PROD_W-1:0] filt_b_sum;
    logic signed [PROD_W-1:0] deg_sum;
    logic                     out_load;

    agtm_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    assign s_axis_tready = (ctrl.seq == SEQ_INPUT);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign smp_a = {{(SUM_W-SAMPLE_W){1'b0}}, s_axis_tdata[SAMPLE_W-1:0]};
    assign smp_b = {{(SUM_W-SAMPLE_W){1'b0}}, s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]};
    assign smp_s = {{(SUM_W-SAMPLE_W){1'b0}}, s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W]};
    assign smp_r = {{(SUM_W-SAMPLE_W){1'b0}}, s_axis_tdata[4*SAMPLE_W-1:3*SAMPLE_W]};

    assign group_count_next = group_count_reg + GC_W'(1);
    assign last_group       = (group_count_next == GC_W'(GROUPS));

    assign out_load      = (ctrl.wr_sel == W_OUT) && cond.out_free;
    assign cond.start    = in_accept && last_group;
    assign cond.out_free = !out_valid_reg || m_axis_tready;

    assign x_sens = ($signed(filt_s_reg[DIV_W-1:0]) <<< 2) + $signed(filt_s_reg[DIV_W-1:0])
                  + ($signed(DIV_W'(cnt_s_reg)) <<< 8) + ($signed(DIV_W'(cnt_s_reg)) <<< 3);

    always_comb
    begin
        unique case (ctrl.div_src)
            D_SUM_A: div_val = DIV_W'($signed(sum_a_reg));
            D_SUM_B: div_val = DIV_W'($signed(sum_b_reg));
            D_SUM_S: div_val = DIV_W'($signed(sum_s_reg));
            default: div_val = x_sens;
        endcase
    end

    assign div_neg = div_val[DIV_W-1];
    assign div_mag = div_neg ? ((-div_val) + (ctrl.div_floor ? FLOOR_ADJ : '0))
                             : div_val;

    always_comb
    begin
        unique case (ctrl.a_sel)
            A_DIV:     mul_a = $signed({{(MUL_W-QUO_W){1'b0}}, div_mag[QUO_W-1:0]});
            A_SCALE_A: mul_a = $signed({1'b0, scale_a_reg});
            A_SCALE_B: mul_a = $signed({1'b0, scale_b_reg});
            default:   mul_a = $signed({2'b0, sensor_v25_reg}) - MUL_W'(filt_s_reg);
        endcase
    end

    always_comb
    begin
        unique case (ctrl.b_sel)
            B_RECIP: mul_b = $signed(RECIP_10);
            B_CNT_A: mul_b = MUL_W'(cnt_a_reg);
            B_CNT_B: mul_b = MUL_W'(cnt_b_reg);
            default: mul_b = $signed({2'b0, inv_slope_reg});
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign quo_mag = prod_reg[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
    assign quo     = sign_reg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});

    assign filt_a_sum = (prod_reg + ((PROD_W'(filt_a_reg) + PROD_W'($signed(offset_a_reg))) <<< 8))
                        >>> 9;
    assign filt_b_sum = (prod_reg + (PROD_W'(filt_b_reg) <<< 8)) >>> 9;
    assign deg_sum    = (prod_reg >>> 16) + DEG_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_a_reg    <= RST_SCALE_A;
            offset_a_reg   <= RST_OFFSET_A;
            scale_b_reg    <= RST_SCALE_B;
            sensor_v25_reg <= RST_SENSOR_V25;
            inv_slope_reg  <= RST_INV_SLOPE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SCALE_A:    scale_a_reg    <= cfg_wdata[VAL_W-1:0];
                REG_OFFSET_A:   offset_a_reg   <= cfg_wdata[VAL_W-1:0];
                REG_SCALE_B:    scale_b_reg    <= cfg_wdata[VAL_W-1:0];
                REG_SENSOR_V25: sensor_v25_reg <= cfg_wdata[UVAL_W-1:0];
                REG_INV_SLOPE:  inv_slope_reg  <= cfg_wdata[UVAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            sum_s_reg       <= '0;
            group_count_reg <= '0;
        end
        else if (in_accept)
        begin
            sum_a_reg       <= sum_a_reg + smp_a - smp_r + REF_NOMINAL;
            sum_b_reg       <= sum_b_reg + smp_b - smp_r + REF_NOMINAL;
            sum_s_reg       <= sum_s_reg + smp_s - smp_r + REF_NOMINAL;
            group_count_reg <= last_group ? '0 : group_count_next;
        end
        else if (out_load)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            sum_s_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_a_reg <= RST_FILT_A;
            filt_b_reg <= RST_FILT_B;
            filt_s_reg <= RST_FILT_S;
        end
        else
        begin
            unique case (ctrl.wr_sel)
                W_FILT_A: filt_a_reg <= sat32(filt_a_sum);
                W_FILT_B: filt_b_reg <= sat32(filt_b_sum);
                W_FILT_S: filt_s_reg <= VAL_W'(quo);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_p;
            sign_reg <= div_neg;
        end
        unique case (ctrl.wr_sel)
            W_CNT_A: cnt_a_reg <= quo[CNT_W-1:0];
            W_CNT_B: cnt_b_reg <= quo[CNT_W-1:0];
            W_CNT_S: cnt_s_reg <= quo[CNT_W-1:0];
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_a_reg   <= filt_a_reg;
            out_b_reg   <= filt_b_reg;
            out_s_reg   <= filt_s_reg;
            out_deg_reg <= sat32(deg_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_deg_reg, out_s_reg, out_b_reg, out_a_reg};

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scan-group averager and temperature monitor.
// A driver feeds scan groups in bursts from a queue. Each accepted group also
// updates an internal fixed-point predictor of the sums, the filters and the
// degrees. A monitor compares each reading with the oldest prediction, field
// by field. The registers are rewritten between phases with typical, random
// and saturating values, and the reader stalls on its own pattern, including
// one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    import agtm_pkg::*;

    localparam int     HALF_PERIOD       = 4;
    localparam int     RESET_CYCLES      = 9;
    localparam int     GROUPS            = GROUPS_DEFAULT;
    localparam int     NOMINAL_REFERENCE = 1489;
    localparam int     COUNT_DIVISOR     = 10;
    localparam longint SENSOR_STEP       = 528;
    localparam longint DEG_AT_V25        = 25 * 65536;
    localparam longint Q16_MAX           = 64'sd2147483647;
    localparam longint Q16_MIN           = -64'sd2147483648;
    localparam int     SETTLE_CYCLES     = 30;
    localparam int     HOLD_OFF_CYCLES   = 250;
    localparam int     HOLD_OFF_AFTER    = 12;
    localparam int     RANDOM_PHASES     = 8;
    localparam int     GROUPS_PER_PHASE  = 72;
    localparam int     CFG_SLOTS         = 1 << CFG_IDX_W;
    localparam int     LIMIT_NS          = 2000000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] reference;
        logic [SAMPLE_W-1:0] sensor;
        logic [SAMPLE_W-1:0] chan_b;
        logic [SAMPLE_W-1:0] chan_a;
    } scan_group_t;

    typedef struct packed {
        logic [VAL_W-1:0] degrees;
        logic [VAL_W-1:0] volts_sensor;
        logic [VAL_W-1:0] volts_chan_b;
        logic [VAL_W-1:0] volts_chan_a;
    } reading_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr      = '0;
    logic [CFG_W-1:0]      cfg_wdata     = '0;
    logic                  hold_off      = 1'b0;

    logic [VAL_W-1:0]        pred_scale_a  = RST_SCALE_A;
    logic signed [VAL_W-1:0] pred_offset_a = RST_OFFSET_A;
    logic [VAL_W-1:0]        pred_scale_b  = RST_SCALE_B;
    logic [UVAL_W-1:0]       pred_v25      = RST_SENSOR_V25;
    logic [UVAL_W-1:0]       pred_slope    = RST_INV_SLOPE;

    int                      run_sum_a     = 0;
    int                      run_sum_b     = 0;
    int                      run_sum_s     = 0;
    int                      groups_in_run = 0;
    logic signed [VAL_W-1:0] filt_a        = RST_FILT_A;
    logic signed [VAL_W-1:0] filt_b        = RST_FILT_B;
    logic signed [VAL_W-1:0] filt_s        = RST_FILT_S;

    scan_group_t      pending_groups[$];
    reading_t         expected_readings[$];
    logic [CFG_W-1:0] next_settings [CFG_SLOTS];

    int groups_queued    = 0;
    int groups_accepted  = 0;
    int readings_checked = 0;
    int register_writes  = 0;
    int failures         = 0;

    int             burst_left   = 0;
    int             gap_left     = 0;
    int             pattern_left = 0;
    int             ready_mode   = 0;
    int             ready_tick   = 0;
    logic [15:0]    ready_bits   = '1;

    adc_group_average_temp_monitor #(
        .GROUPS(GROUPS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic longint floor_div(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic logic [VAL_W-1:0] clamp_q16(input longint v);
        logic [VAL_W-1:0] r;
        if (v > Q16_MAX)
        begin
            r = Q16_MAX[VAL_W-1:0];
        end
        else if (v < Q16_MIN)
        begin
            r = Q16_MIN[VAL_W-1:0];
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic void accumulate_group(input scan_group_t g);
        int       corr;
        int       count_a;
        int       count_b;
        int       count_s;
        longint   diff;
        reading_t r;
        corr = int'(g.reference) - NOMINAL_REFERENCE;
        run_sum_a += int'(g.chan_a) - corr;
        run_sum_b += int'(g.chan_b) - corr;
        run_sum_s += int'(g.sensor) - corr;
        groups_in_run++;
        if (groups_in_run < GROUPS)
        begin
            return;
        end
        count_a = run_sum_a / COUNT_DIVISOR;
        count_b = run_sum_b / COUNT_DIVISOR;
        count_s = run_sum_s / COUNT_DIVISOR;
        filt_a = clamp_q16(floor_div(longint'(filt_a) * 256
                 + longint'(pred_scale_a) * count_a + longint'(pred_offset_a) * 256, 512));
        filt_b = clamp_q16(floor_div(longint'(filt_b) * 256
                 + longint'(pred_scale_b) * count_b, 512));
        filt_s = clamp_q16(floor_div(longint'(filt_s) * 10
                 + longint'(count_s) * SENSOR_STEP, 20));
        diff = longint'(pred_v25) - longint'(filt_s);
        r.volts_chan_a = filt_a;
        r.volts_chan_b = filt_b;
        r.volts_sensor = filt_s;
        r.degrees      = clamp_q16(floor_div(diff * longint'(pred_slope), 65536) + DEG_AT_V25);
        expected_readings.push_back(r);
        run_sum_a     = 0;
        run_sum_b     = 0;
        run_sum_s     = 0;
        groups_in_run = 0;
    endfunction

    function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                        input logic [VAL_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            failures++;
        end
    endfunction

    function automatic logic [CFG_W-1:0] pick_setting(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                case (idx)
                    REG_SCALE_A:    v = $urandom_range(50000, 300000);
                    REG_OFFSET_A:   v = $urandom_range(0, 131072) - 65536;
                    REG_SCALE_B:    v = $urandom_range(10000, 100000);
                    REG_SENSOR_V25: v = $urandom_range(80000, 100000);
                    REG_INV_SLOPE:  v = $urandom_range(10000000, 20000000);
                    default:        v = $urandom;
                endcase
            end
            2:       v = $urandom;
            3:       v = '0;
            4:       v = '1;
            default: v = {1'b1, {(CFG_W - 1){1'b0}}};
        endcase
        return v;
    endfunction

    function automatic scan_group_t random_group();
        scan_group_t g;
        g = IN_DATA_W'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 7)
        begin
            g.reference = SAMPLE_W'(NOMINAL_REFERENCE - 100 + int'($urandom_range(0, 200)));
        end
        if ($urandom_range(0, 19) == 0)
        begin
            g.chan_a = '1;
            g.sensor = '0;
        end
        return g;
    endfunction

    task automatic queue_group(input scan_group_t g);
        pending_groups.push_back(g);
        groups_queued++;
    endtask

    task automatic queue_random_groups(input int count);
        for (int i = 0; i < count; i++)
        begin
            queue_group(random_group());
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_SCALE_A:    pred_scale_a  = value;
            REG_OFFSET_A:   pred_offset_a = value;
            REG_SCALE_B:    pred_scale_b  = value;
            REG_SENSOR_V25: pred_v25      = value[UVAL_W-1:0];
            REG_INV_SLOPE:  pred_slope    = value[UVAL_W-1:0];
            default:        ;
        endcase
        register_writes++;
    endtask

    // Slots past the last register receive junk, which must leave the settings unchanged.
    task automatic load_settings();
        for (int idx = 0; idx < CFG_SLOTS; idx++)
        begin
            write_register(CFG_IDX_W'(idx), next_settings[idx]);
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (groups_accepted != groups_queued || expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_groups
        logic                 next_valid;
        logic [IN_DATA_W-1:0] next_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            next_data  = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                accumulate_group(scan_group_t'(s_axis_tdata));
                groups_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_groups.size() > 0)
                begin
                    next_valid = 1'b1;
                    next_data  = pending_groups.pop_front();
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_readings
        reading_t got;
        reading_t want;
        logic     next_ready;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_readings.size() == 0)
                begin
                    $error("reading transaction arrived with none expected: %h", m_axis_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("volts_chan_a", want.volts_chan_a, got.volts_chan_a);
                    check_field("volts_chan_b", want.volts_chan_b, got.volts_chan_b);
                    check_field("volts_sensor", want.volts_sensor, got.volts_sensor);
                    check_field("degrees", want.degrees, got.degrees);
                end
                readings_checked++;
            end
            if (pattern_left == 0)
            begin
                ready_mode   = $urandom_range(0, 2);
                ready_bits   = 16'($urandom);
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            ready_tick++;
            case (ready_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = ready_bits[4'(ready_tick % 16)];
                default: next_ready = (ready_tick % 5 == 0);
            endcase
            m_axis_tready <= next_ready && !hold_off;
        end
    end

    initial
    begin : receiver_hold_off
        while (readings_checked < HOLD_OFF_AFTER)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $error("run timed out with %0d readings outstanding", expected_readings.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : run_phases
        scan_group_t g;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        queue_random_groups(3 * GROUPS);
        wait_until_drained();

        // Largest sums under the largest settings, then the most negative sums.
        next_settings[REG_SCALE_A]    = '1;
        next_settings[REG_OFFSET_A]   = {1'b0, {(CFG_W - 1){1'b1}}};
        next_settings[REG_SCALE_B]    = '1;
        next_settings[REG_SENSOR_V25] = '1;
        next_settings[REG_INV_SLOPE]  = '1;
        for (int idx = int'(REG_INV_SLOPE) + 1; idx < CFG_SLOTS; idx++)
        begin
            next_settings[idx] = $urandom;
        end
        load_settings();
        g = '{reference: '0, sensor: '1, chan_b: '1, chan_a: '1};
        for (int i = 0; i < GROUPS; i++)
        begin
            queue_group(g);
        end
        g = '{reference: '1, sensor: '0, chan_b: '0, chan_a: '0};
        for (int i = 0; i < GROUPS; i++)
        begin
            queue_group(g);
        end
        wait_until_drained();

        next_settings[REG_SCALE_A]    = '0;
        next_settings[REG_OFFSET_A]   = {1'b1, {(CFG_W - 1){1'b0}}};
        next_settings[REG_SCALE_B]    = 1;
        next_settings[REG_SENSOR_V25] = '0;
        next_settings[REG_INV_SLOPE]  = '1;
        load_settings();
        queue_random_groups(4 * GROUPS);
        wait_until_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int idx = 0; idx < CFG_SLOTS; idx++)
            begin
                next_settings[idx] = pick_setting(CFG_IDX_W'(idx));
            end
            load_settings();
            queue_random_groups(GROUPS_PER_PHASE);
            wait_until_drained();
        end

        if (expected_readings.size() != 0)
        begin
            $error("%0d expected readings never arrived", expected_readings.size());
            failures += expected_readings.size();
        end
        $display("Covered %0d scan groups and %0d readings over %0d register writes.",
                 groups_accepted, readings_checked, register_writes);
        $display("Settings ran from reset values through saturating extremes to %0d random sets.",
                 RANDOM_PHASES);
        if (failures == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: adc_group_average_temp_monitor.f
rtl/agtm_pkg.sv
rtl/agtm_sequencer.sv
rtl/adc_group_average_temp_monitor.sv
test/testbench.sv
